### src/cfr_pkg.sv
package cfr_pkg;

  localparam int unsigned DataW = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned FrameLen = 6;
  localparam int unsigned PosW = 3;
  localparam int unsigned TxIdxW = 3;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW = $clog2(QueueDepth + 1);

  localparam logic [CfgIdxW-1:0] REG_START_BYTE = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_END_BYTE = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_STATION_ID = 2'd2;

  localparam logic [DataW-1:0] RESET_START_BYTE = 8'd2;
  localparam logic [DataW-1:0] RESET_END_BYTE = 8'd3;
  localparam logic [DataW-1:0] RESET_STATION_ID = 8'd1;

  localparam logic [DataW-1:0] CHAR_A = 8'h41;
  localparam logic [DataW-1:0] CHAR_C = 8'h43;
  localparam logic [DataW-1:0] CHAR_K = 8'h4B;
  localparam logic [DataW-1:0] CHAR_N = 8'h4E;

  // Checksum of a response body without the start byte, modulo 256.
  localparam logic [DataW-1:0] ACK_BODY_SUM = CHAR_A + CHAR_C + CHAR_K;
  localparam logic [DataW-1:0] NACK_BODY_SUM = CHAR_N + CHAR_A + CHAR_C + CHAR_K;

  // Position of the checksum byte within a collected frame.
  localparam logic [PosW-1:0] POS_CHECKSUM = PosW'(FrameLen - 1);

  localparam logic [TxIdxW-1:0] ACK_LAST_IDX = 3'd5;
  localparam logic [TxIdxW-1:0] NACK_LAST_IDX = 3'd6;

  localparam logic RT_RESPONSE = 1'b0;
  localparam logic RT_UPDATE = 1'b1;

  typedef enum logic [1:0] {
    KIND_ACK,
    KIND_NACK,
    KIND_UPDATE
  } cfr_kind_e;

  typedef struct packed {
    cfr_kind_e        kind;
    logic [DataW-1:0] interval;
    logic [DataW-1:0] count;
    logic [DataW-1:0] mask;
  } cfr_cmd_t;

  typedef struct packed {
    logic     valid;
    cfr_cmd_t cmd;
  } cfr_push_t;

endpackage

### src/config_frame_receiver.sv
// Configuration frame receiver.
// Input channel: in_valid_i / in_stall_o carry one received byte per item on
// rx_byte_i. Output channel: out_valid_o / out_stall_i carry result items:
// response bytes (result_type_o = 0, last_o on the end byte) or one
// configuration update (result_type_o = 1) with interval, count and mask.
// Registers start_byte, end_byte and station_id are written through
// cfg_we_i, cfg_index_i and cfg_wdata_i; index 3 is ignored.
// A byte is taken every cycle while in_stall_o is low. The checksum byte or
// a matching apply byte pushes one command into a two-entry queue; the back
// end expands it into 7 (NACK), 6 (ACK) or 1 (update) items, one per cycle
// while out_stall_i is low. A command passes the front's push register and
// the queue before the output register takes its first result.
// in_stall_o is high while a command waits in the queue: after a checksum
// byte one more byte can still enter, then the input pauses until the queue
// is empty again, which out_stall_i can delay. The output register keeps a
// finished item while out_stall_i is high and loads the next one as soon as
// it is taken.
// Reset puts the receiver back to hunting for a start byte, empties the queue
// and the output register, and restores the register reset values.
module config_frame_receiver (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [cfr_pkg::DataW-1:0]   rx_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        result_type_o,
  output logic [cfr_pkg::DataW-1:0]   tx_byte_o,
  output logic                        last_o,
  output logic [cfr_pkg::DataW-1:0]   sample_interval_o,
  output logic [cfr_pkg::DataW-1:0]   sample_count_o,
  output logic [cfr_pkg::DataW-1:0]   enable_mask_o,
  input  logic                        cfg_we_i,
  input  logic [cfr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [cfr_pkg::DataW-1:0]   cfg_wdata_i
);

  logic [cfr_pkg::DataW-1:0] start_byte_q, end_byte_q, station_id_q;
  logic                      accept;
  logic                      almost_full;
  logic                      empty;
  logic                      pop;
  cfr_pkg::cfr_push_t        push;
  cfr_pkg::cfr_cmd_t         head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= cfr_pkg::RESET_START_BYTE;
      end_byte_q <= cfr_pkg::RESET_END_BYTE;
      station_id_q <= cfr_pkg::RESET_STATION_ID;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        cfr_pkg::REG_START_BYTE: start_byte_q <= cfg_wdata_i;
        cfr_pkg::REG_END_BYTE:   end_byte_q <= cfg_wdata_i;
        cfr_pkg::REG_STATION_ID: station_id_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = almost_full;
  assign accept = in_valid_i && !in_stall_o;

  cfr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .rx_byte_i    (rx_byte_i),
    .start_byte_i (start_byte_q),
    .station_id_i (station_id_q),
    .push_o       (push)
  );

  cfr_queue u_queue (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .pop_i         (pop),
    .empty_o       (empty),
    .almost_full_o (almost_full),
    .head_o        (head)
  );

  cfr_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .empty_i           (empty),
    .head_i            (head),
    .pop_o             (pop),
    .start_byte_i      (start_byte_q),
    .end_byte_i        (end_byte_q),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .result_type_o     (result_type_o),
    .tx_byte_o         (tx_byte_o),
    .last_o            (last_o),
    .sample_interval_o (sample_interval_o),
    .sample_count_o    (sample_count_o),
    .enable_mask_o     (enable_mask_o)
  );

endmodule

### src/cfr_front.sv
module cfr_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic [cfr_pkg::DataW-1:0] rx_byte_i,
  input  logic [cfr_pkg::DataW-1:0] start_byte_i,
  input  logic [cfr_pkg::DataW-1:0] station_id_i,
  output cfr_pkg::cfr_push_t        push_o
);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_COLLECT,
    PH_APPLY
  } phase_e;

  phase_e                         phase_q, phase_d;
  logic [cfr_pkg::PosW-1:0]       pos_q, pos_d;
  logic [cfr_pkg::DataW-1:0]      sum_q, sum_d;
  logic [cfr_pkg::DataW-1:0]      station_q, interval_q, smp_count_q, mask_q;
  cfr_pkg::cfr_push_t             push_d;

  always_comb begin
    phase_d = phase_q;
    pos_d = pos_q;
    sum_d = sum_q;
    push_d = '0;
    push_d.cmd.interval = interval_q;
    push_d.cmd.count = smp_count_q;
    push_d.cmd.mask = mask_q;
    push_d.cmd.kind = cfr_pkg::KIND_ACK;
    if (accept_i) begin
      unique case (phase_q)
        PH_COLLECT: begin
          if (pos_q == cfr_pkg::POS_CHECKSUM) begin
            push_d.valid = 1'b1;
            pos_d = '0;
            if (sum_q == rx_byte_i) begin
              push_d.cmd.kind = cfr_pkg::KIND_ACK;
              phase_d = PH_APPLY;
            end else begin
              push_d.cmd.kind = cfr_pkg::KIND_NACK;
              phase_d = PH_HUNT;
            end
          end else begin
            sum_d = sum_q + rx_byte_i;
            pos_d = pos_q + 3'd1;
          end
        end
        PH_APPLY: begin
          // The apply byte's value is ignored, even if it equals the start byte.
          phase_d = PH_HUNT;
          pos_d = '0;
          if (station_q == station_id_i) begin
            push_d.valid = 1'b1;
            push_d.cmd.kind = cfr_pkg::KIND_UPDATE;
          end
        end
        default: begin
          if (rx_byte_i == start_byte_i) begin
            phase_d = PH_COLLECT;
            pos_d = '0;
            sum_d = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      pos_q <= '0;
      sum_q <= '0;
      push_o <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q <= pos_d;
      sum_q <= sum_d;
      push_o <= push_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && phase_q == PH_COLLECT) begin
      unique case (pos_q)
        3'd0:    station_q <= rx_byte_i;
        3'd2:    interval_q <= rx_byte_i;
        3'd3:    smp_count_q <= rx_byte_i;
        3'd4:    mask_q <= rx_byte_i;
        default: ;
      endcase
    end
  end

  a_pos_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= cfr_pkg::POS_CHECKSUM)
    else $error("frame position beyond checksum byte");

  a_push_needs_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.valid |-> $past(accept_i))
    else $error("command pushed without an accepted byte");

endmodule

### src/cfr_queue.sv
module cfr_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfr_pkg::cfr_push_t push_i,
  input  logic               pop_i,
  output logic               empty_o,
  output logic               almost_full_o,
  output cfr_pkg::cfr_cmd_t  head_o
);

  cfr_pkg::cfr_cmd_t                   entries_q [cfr_pkg::QueueDepth];
  logic [cfr_pkg::QueuePtrW-1:0]       wr_ptr_q, rd_ptr_q;
  logic [cfr_pkg::QueueCntW-1:0]       count_q;
  logic                                do_pop;

  localparam logic [cfr_pkg::QueuePtrW-1:0] PtrLast = cfr_pkg::QueuePtrW'(cfr_pkg::QueueDepth - 1);
  localparam logic [cfr_pkg::QueueCntW-1:0] CntFull = cfr_pkg::QueueCntW'(cfr_pkg::QueueDepth);

  assign empty_o = (count_q == '0);
  // A push may already be in flight from the front, so the byte side stops
  // one entry early.
  assign almost_full_o = (count_q >= CntFull - cfr_pkg::QueueCntW'(1));
  assign head_o = entries_q[rd_ptr_q];
  assign do_pop = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      if (push_i.valid) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({push_i.valid, do_pop})
        2'b10:   count_q <= count_q + cfr_pkg::QueueCntW'(1);
        2'b01:   count_q <= count_q - cfr_pkg::QueueCntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      entries_q[wr_ptr_q] <= push_i.cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.valid |-> (count_q != CntFull) || do_pop)
    else $error("push into full command queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntFull)
    else $error("command queue count out of range");

endmodule

### src/cfr_back.sv
module cfr_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      empty_i,
  input  cfr_pkg::cfr_cmd_t         head_i,
  output logic                      pop_o,
  input  logic [cfr_pkg::DataW-1:0] start_byte_i,
  input  logic [cfr_pkg::DataW-1:0] end_byte_i,
  input  logic                      out_stall_i,
  output logic                      out_valid_o,
  output logic                      result_type_o,
  output logic [cfr_pkg::DataW-1:0] tx_byte_o,
  output logic                      last_o,
  output logic [cfr_pkg::DataW-1:0] sample_interval_o,
  output logic [cfr_pkg::DataW-1:0] sample_count_o,
  output logic [cfr_pkg::DataW-1:0] enable_mask_o
);

  logic [cfr_pkg::TxIdxW-1:0] idx_q;
  logic                       valid_q;
  logic                       load;
  logic                       is_last;
  logic [cfr_pkg::DataW-1:0]  byte_d;

  assign load = !empty_i && (!valid_q || !out_stall_i);

  always_comb begin
    byte_d = '0;
    is_last = 1'b0;
    unique case (head_i.kind)
      cfr_pkg::KIND_ACK: begin
        is_last = (idx_q == cfr_pkg::ACK_LAST_IDX);
        unique case (idx_q)
          3'd0:    byte_d = start_byte_i;
          3'd1:    byte_d = cfr_pkg::CHAR_A;
          3'd2:    byte_d = cfr_pkg::CHAR_C;
          3'd3:    byte_d = cfr_pkg::CHAR_K;
          3'd4:    byte_d = start_byte_i + cfr_pkg::ACK_BODY_SUM;
          default: byte_d = end_byte_i;
        endcase
      end
      cfr_pkg::KIND_NACK: begin
        is_last = (idx_q == cfr_pkg::NACK_LAST_IDX);
        unique case (idx_q)
          3'd0:    byte_d = start_byte_i;
          3'd1:    byte_d = cfr_pkg::CHAR_N;
          3'd2:    byte_d = cfr_pkg::CHAR_A;
          3'd3:    byte_d = cfr_pkg::CHAR_C;
          3'd4:    byte_d = cfr_pkg::CHAR_K;
          3'd5:    byte_d = start_byte_i + cfr_pkg::NACK_BODY_SUM;
          default: byte_d = end_byte_i;
        endcase
      end
      default: begin
        is_last = 1'b1;
      end
    endcase
  end

  assign pop_o = load && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q <= is_last ? '0 : idx_q + 3'd1;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      tx_byte_o <= byte_d;
      last_o <= is_last;
      if (head_i.kind == cfr_pkg::KIND_UPDATE) begin
        result_type_o <= cfr_pkg::RT_UPDATE;
        sample_interval_o <= head_i.interval;
        sample_count_o <= head_i.count;
        enable_mask_o <= head_i.mask;
      end else begin
        result_type_o <= cfr_pkg::RT_RESPONSE;
        sample_interval_o <= '0;
        sample_count_o <= '0;
        enable_mask_o <= '0;
      end
    end
  end

  assign out_valid_o = valid_q;

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= cfr_pkg::NACK_LAST_IDX)
    else $error("response byte index out of range");

  a_idx_reset_on_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> idx_q == '0)
    else $error("byte index not cleared after last byte");

endmodule

### bench/config_frame_receiver_tb.sv
`timescale 1ns / 100ps

module config_frame_receiver_tb;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned SettleCycles = 20;
  localparam int unsigned NumSettings = 5;
  localparam int unsigned ItemsPerSetting = 20;
  localparam int unsigned HoldOffCycles = 300;

  localparam logic [cfr_pkg::CfgIdxW-1:0] REG_UNUSED = 2'd3;

  // Byte positions inside a collected frame.
  localparam int unsigned FB_STATION = 0;
  localparam int unsigned FB_INTERVAL = 2;
  localparam int unsigned FB_COUNT = 3;
  localparam int unsigned FB_MASK = 4;

  typedef enum logic [1:0] {
    RX_HUNT,
    RX_COLLECT,
    RX_APPLY
  } rx_phase_e;

  typedef struct packed {
    logic                      result_type;
    logic [cfr_pkg::DataW-1:0] tx_byte;
    logic                      last;
    logic [cfr_pkg::DataW-1:0] interval;
    logic [cfr_pkg::DataW-1:0] count;
    logic [cfr_pkg::DataW-1:0] mask;
  } rx_result_t;

  class frame_scoreboard;
    logic [cfr_pkg::DataW-1:0] cfg_start;
    logic [cfr_pkg::DataW-1:0] cfg_end;
    logic [cfr_pkg::DataW-1:0] cfg_station;
    rx_phase_e                 phase;
    logic [cfr_pkg::PosW-1:0]  pos;
    logic [cfr_pkg::DataW-1:0] frame_bytes [cfr_pkg::FrameLen];
    rx_result_t                expected_q [$];
    int errors;
    int n_bytes;
    int n_results;
    int n_acks;
    int n_nacks;
    int n_updates;

    function new();
      cfg_start = cfr_pkg::RESET_START_BYTE;
      cfg_end = cfr_pkg::RESET_END_BYTE;
      cfg_station = cfr_pkg::RESET_STATION_ID;
      phase = RX_HUNT;
      pos = '0;
      errors = 0;
      n_bytes = 0;
      n_results = 0;
      n_acks = 0;
      n_nacks = 0;
      n_updates = 0;
    endfunction

    function void write_reg(logic [cfr_pkg::CfgIdxW-1:0] idx,
                            logic [cfr_pkg::DataW-1:0] value);
      case (idx)
        cfr_pkg::REG_START_BYTE: cfg_start = value;
        cfr_pkg::REG_END_BYTE: cfg_end = value;
        cfr_pkg::REG_STATION_ID: cfg_station = value;
        default: ;
      endcase
    endfunction

    function void add_tx(logic [cfr_pkg::DataW-1:0] b, logic is_last);
      rx_result_t r;
      r = '{cfr_pkg::RT_RESPONSE, b, is_last, 8'h00, 8'h00, 8'h00};
      expected_q.push_back(r);
    endfunction

    // Response bytes use the start and end bytes as they stand right now.
    function void push_response(logic is_nack);
      logic [cfr_pkg::DataW-1:0] body [$];
      logic [cfr_pkg::DataW-1:0] sum;
      if (is_nack) begin
        body = '{cfr_pkg::CHAR_N, cfr_pkg::CHAR_A, cfr_pkg::CHAR_C, cfr_pkg::CHAR_K};
        n_nacks++;
      end else begin
        body = '{cfr_pkg::CHAR_A, cfr_pkg::CHAR_C, cfr_pkg::CHAR_K};
        n_acks++;
      end
      sum = cfg_start;
      add_tx(cfg_start, 1'b0);
      foreach (body[i]) begin
        add_tx(body[i], 1'b0);
        sum += body[i];
      end
      add_tx(sum, 1'b0);
      add_tx(cfg_end, 1'b1);
    endfunction

    function void note_input(logic [cfr_pkg::DataW-1:0] b);
      logic [cfr_pkg::DataW-1:0] sum;
      rx_result_t upd;
      n_bytes++;
      case (phase)
        RX_COLLECT: begin
          frame_bytes[pos] = b;
          if (pos != cfr_pkg::POS_CHECKSUM) begin
            pos++;
          end else begin
            pos = '0;
            sum = '0;
            for (int i = 0; i < cfr_pkg::FrameLen - 1; i++) sum += frame_bytes[i];
            if (sum == frame_bytes[cfr_pkg::POS_CHECKSUM]) begin
              phase = RX_APPLY;
              push_response(1'b0);
            end else begin
              phase = RX_HUNT;
              push_response(1'b1);
            end
          end
        end
        RX_APPLY: begin
          // The byte itself is ignored; only the stored frame matters.
          phase = RX_HUNT;
          pos = '0;
          if (frame_bytes[FB_STATION] == cfg_station) begin
            upd = '{cfr_pkg::RT_UPDATE, 8'h00, 1'b1, frame_bytes[FB_INTERVAL],
                    frame_bytes[FB_COUNT], frame_bytes[FB_MASK]};
            expected_q.push_back(upd);
            n_updates++;
          end
        end
        default: begin
          phase = RX_HUNT;
          if (b == cfg_start) begin
            phase = RX_COLLECT;
            pos = '0;
          end
        end
      endcase
    endfunction

    function void match_field(string name, logic [cfr_pkg::DataW-1:0] exp_v,
                              logic [cfr_pkg::DataW-1:0] act_v);
      if (act_v !== exp_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(rx_result_t got);
      rx_result_t want;
      n_results++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = expected_q.pop_front();
      match_field("result_type", cfr_pkg::DataW'(want.result_type),
                  cfr_pkg::DataW'(got.result_type));
      match_field("tx_byte", want.tx_byte, got.tx_byte);
      match_field("last", cfr_pkg::DataW'(want.last), cfr_pkg::DataW'(got.last));
      match_field("sample_interval", want.interval, got.interval);
      match_field("sample_count", want.count, got.count);
      match_field("enable_mask", want.mask, got.mask);
    endfunction
  endclass

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic [cfr_pkg::DataW-1:0]   rx_byte_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic                        result_type_o;
  logic [cfr_pkg::DataW-1:0]   tx_byte_o;
  logic                        last_o;
  logic [cfr_pkg::DataW-1:0]   sample_interval_o;
  logic [cfr_pkg::DataW-1:0]   sample_count_o;
  logic [cfr_pkg::DataW-1:0]   enable_mask_o;
  logic                        cfg_we_i;
  logic [cfr_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [cfr_pkg::DataW-1:0]   cfg_wdata_i;

  frame_scoreboard sb;
  bit  hold_req;
  bit  tx_calm;
  int  cycle_count;
  int  phase_items;
  int  settings_used;

  // Noise byte, a good frame with an update, a bad checksum, and a good
  // frame addressed to another station.
  logic [cfr_pkg::DataW-1:0] directed_bytes [$] = '{
    8'h00,
    8'h02, 8'h01, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h02,
    8'h02, 8'h05, 8'h7E, 8'h01, 8'h80, 8'h00, 8'h00,
    8'h02, 8'h09, 8'h01, 8'h02, 8'h03, 8'h04, 8'h13, 8'hAA
  };

  config_frame_receiver u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .rx_byte_i         (rx_byte_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .result_type_o     (result_type_o),
    .tx_byte_o         (tx_byte_o),
    .last_o            (last_o),
    .sample_interval_o (sample_interval_o),
    .sample_count_o    (sample_count_o),
    .enable_mask_o     (enable_mask_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_byte(logic [cfr_pkg::DataW-1:0] b);
    int gap;
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(b);
  endtask

  // A frame with random content; most are well formed, some carry a bad
  // checksum and a few are cut short so that the next frame runs into them.
  task automatic send_frame();
    logic [cfr_pkg::DataW-1:0] fb [cfr_pkg::FrameLen];
    logic [cfr_pkg::DataW-1:0] sum;
    int cut;
    tx_calm = ($urandom_range(0, 3) == 0);
    fb[FB_STATION] = ($urandom_range(0, 9) < 6) ? sb.cfg_station : 8'($urandom);
    sum = fb[FB_STATION];
    for (int i = 1; i < cfr_pkg::FrameLen - 1; i++) begin
      fb[i] = 8'($urandom);
      sum += fb[i];
    end
    fb[cfr_pkg::FrameLen - 1] = ($urandom_range(0, 4) != 0) ? sum :
                                sum ^ (8'h01 << $urandom_range(0, 7));
    cut = ($urandom_range(0, 11) == 0) ? $urandom_range(1, 5) : cfr_pkg::FrameLen;
    send_byte(sb.cfg_start);
    for (int i = 0; i < cut; i++) send_byte(fb[i]);
    phase_items += cut + 1;
    if (cut == cfr_pkg::FrameLen && fb[cfr_pkg::FrameLen - 1] == sum) begin
      send_byte(($urandom_range(0, 3) == 0) ? sb.cfg_start : 8'($urandom));
      phase_items++;
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic load_settings(logic [cfr_pkg::DataW-1:0] s,
                               logic [cfr_pkg::DataW-1:0] e,
                               logic [cfr_pkg::DataW-1:0] st);
    logic [cfr_pkg::CfgIdxW-1:0] idx [4];
    logic [cfr_pkg::DataW-1:0]   val [4];
    idx = '{cfr_pkg::REG_START_BYTE, cfr_pkg::REG_END_BYTE, cfr_pkg::REG_STATION_ID,
            REG_UNUSED};
    val = '{s, e, st, 8'($urandom)};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_wdata_i <= val[i];
      @(posedge clk_i);
      sb.write_reg(idx[i], val[i]);
    end
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // Output side: checks every result taken and stalls at random, with one
  // long hold-off when asked for so that the block backs up.
  initial begin
    int hold_left;
    int stall_left;
    int quiet_left;
    rx_result_t got;
    hold_left = 0;
    stall_left = 0;
    quiet_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got = '{result_type_o, tx_byte_o, last_o, sample_interval_o,
                sample_count_o, enable_mask_o};
        sb.check_result(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HoldOffCycles;
        out_stall_i <= 1'b1;
      end else if (quiet_left > 0) begin
        quiet_left--;
        out_stall_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        if ($urandom_range(0, 3) == 0) quiet_left = $urandom_range(10, 40);
        else stall_left = pick_gap();
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timeout after %0d cycles", cycle_count);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [cfr_pkg::DataW-1:0] s;
    logic [cfr_pkg::DataW-1:0] e;
    logic [cfr_pkg::DataW-1:0] st;
    sb = new();
    hold_req = 1'b0;
    tx_calm = 1'b0;
    settings_used = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    rx_byte_i = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_wdata_i = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

    for (int p = 0; p < NumSettings; p++) begin
      drain();
      case (p)
        0: begin s = 8'h00; e = 8'h00; st = 8'h00; end
        1: begin s = 8'hFF; e = 8'hFF; st = 8'hFF; end
        // With this start byte the ACK checksum wraps to zero.
        2: begin s = 8'h31; e = 8'h00; st = 8'h80; end
        default: begin s = 8'($urandom); e = 8'($urandom); st = 8'($urandom); end
      endcase
      load_settings(s, e, st);
      if (p == 0) hold_req = 1'b1;
      phase_items = 0;
      while (phase_items < ItemsPerSetting) begin
        tx_calm = 1'b0;
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
        end
        send_frame();
      end
    end

    drain();
    foreach (sb.expected_q[i]) begin
      sb.errors++;
      $display("%0t: missing result, expected %h, actual none", $time, sb.expected_q[i]);
    end
    $display("Covered %0d bytes: %0d ACK and %0d NACK frames, %0d configuration updates,",
             sb.n_bytes, sb.n_acks, sb.n_nacks, sb.n_updates);
    $display("%0d results checked over %0d register settings with a long output hold-off.",
             sb.n_results, settings_used);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### config_frame_receiver.f
src/cfr_pkg.sv
src/cfr_front.sv
src/cfr_queue.sv
src/cfr_back.sv
src/config_frame_receiver.sv
bench/config_frame_receiver_tb.sv
